@@ hw/rtl/wca_pkg.sv @@
// Shared constants, codes and divider request/response types for the
// windowed current average block. No dependencies.
package wca_pkg;

	// Store depth default and fixed field widths
	localparam int MAX_WINDOW_DEF = 64;
	localparam int SAMPLE_W       = 16;
	localparam int WL_W           = 7;
	localparam int FILL_W         = 7;
	localparam int SUM_W          = 22;
	// Mode 0 sum: up to 127 samples of 16 bits
	localparam int ACC_W          = SAMPLE_W + WL_W;
	localparam int DIV_CNT_W      = $clog2(ACC_W + 1);

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SAMPLE_W-1:0] NOT_READY = 16'hFFFF;

	// Register reset values
	localparam logic [WL_W-1:0] WL_RESET   = 7'd16;
	localparam logic            MODE_RESET = 1'b1;

	// Register index, taken from paddr[2]
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_MODE   = 1'b1;

	// Averaging modes
	localparam logic MODE_FULL = 1'b0;
	localparam logic MODE_WARM = 1'b1;

	// Input operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  dividend;
		logic [WL_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ACC_W-1:0]  quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/wca_if.sv @@
// Valid/ready channel interfaces for samples in and results out.
// Depends on wca_pkg for field widths.
interface wca_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [wca_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output op, output sample, input ready);
	modport sink   (input valid, input op, input sample, output ready);
endinterface

interface wca_result_if;
	logic                          valid;
	logic                          ready;
	logic [wca_pkg::SAMPLE_W-1:0]  latest_sample;
	logic [wca_pkg::SAMPLE_W-1:0]  average;
	logic [wca_pkg::SAMPLE_W-1:0]  published_average;
	logic                          accepted;

	modport source (output valid, output latest_sample, output average,
		output published_average, output accepted, input ready);
	modport sink   (input valid, input latest_sample, input average,
		input published_average, input accepted, output ready);
endinterface

@@ hw/rtl/wca_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wca_pkg for widths and the request/response structs.
module wca_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wca_pkg::div_req_t  req,
	output wca_pkg::div_rsp_t  rsp
);

	logic [wca_pkg::ACC_W-1:0]     quo_q;
	logic [wca_pkg::WL_W-1:0]      rem_q;
	logic [wca_pkg::WL_W-1:0]      divr_q;
	logic [wca_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [wca_pkg::WL_W:0] trial;
	logic [wca_pkg::WL_W:0] trial_sub;
	logic                   qbit;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial     = {rem_q, quo_q[wca_pkg::ACC_W-1]};
		trial_sub = trial - {1'b0, divr_q};
		qbit      = (trial >= {1'b0, divr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			divr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= wca_pkg::DIV_CNT_W'(wca_pkg::ACC_W);
				quo_q  <= req.dividend;
				rem_q  <= '0;
				divr_q <= req.divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[wca_pkg::ACC_W-2:0], qbit};
				rem_q <= qbit ? trial_sub[wca_pkg::WL_W-1:0] : trial[wca_pkg::WL_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wca_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hw/rtl/windowed_current_average_core.sv @@
// Windowed current average: ring store of samples, running sum, shared divider.
// Full-window mode sweeps the store (ST_SUM) and then divides (ST_DIV); warm-up mode
// reads the old entry (ST_OLD) and then divides; a clear or a skipped sample goes to ST_DONE.
// One item in flight: a new transfer is taken in the cycle after the result loads;
// the serial store sweep and the divider set the time per item.
// Reset (arst_n, asynchronous) clears all state; store entries are marked empty
// by per-entry valid bits and read as zero, so there is no clearing pass.
module windowed_current_average_core #(
	parameter int MAX_WINDOW = wca_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wca_pkg::PADDR_W-1:0]  paddr,
	input  logic [wca_pkg::PDATA_W-1:0]  pwdata,
	output logic [wca_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	wca_sample_if.sink                   samples,
	wca_result_if.source                 results
);

	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_W = (PTR_W + 1 > wca_pkg::WL_W) ? PTR_W + 1 : wca_pkg::WL_W;

	typedef enum logic [2:0] {ST_IDLE, ST_SUM, ST_OLD, ST_DIV, ST_DONE} state_t;

	// Configuration registers
	logic [wca_pkg::WL_W-1:0] wl_q;
	logic                     mode_q;

	// Filter state
	state_t                           state_q;
	logic [PTR_W-1:0]                 ptr_q;
	logic [wca_pkg::FILL_W-1:0]       fill_q;
	logic [wca_pkg::SUM_W-1:0]        sum_q;
	logic [wca_pkg::SAMPLE_W-1:0]     held_q;
	logic [wca_pkg::SAMPLE_W-1:0]     bus_q;
	logic [wca_pkg::SAMPLE_W-1:0]     last_q;
	logic [wca_pkg::SAMPLE_W-1:0]     smp_q;
	logic                             acc_flag_q;
	logic                             wrap_q;
	logic                             div_zero_q;
	logic [CMP_W-1:0]                 idx_q;
	logic [wca_pkg::ACC_W-1:0]        acc_q;

	// Result register
	logic                             out_vld_q;
	logic [wca_pkg::SAMPLE_W-1:0]     out_latest_q;
	logic [wca_pkg::SAMPLE_W-1:0]     out_avg_q;
	logic [wca_pkg::SAMPLE_W-1:0]     out_pub_q;
	logic                             out_acc_q;

	// Sample store
	logic [wca_pkg::SAMPLE_W-1:0]     mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]            valid_q;
	logic [wca_pkg::SAMPLE_W-1:0]     rd_data_q;
	logic                             rd_vld_q;

	logic                             in_xfer;
	logic                             clr_xfer;
	logic                             full_store;
	logic                             mem_we;
	logic [PTR_W-1:0]                 rd_addr;
	logic [wca_pkg::SAMPLE_W-1:0]     wr_data;
	logic [wca_pkg::SAMPLE_W-1:0]     rd_word;
	logic [CMP_W-1:0]                 wl_ext;
	logic [CMP_W-1:0]                 win;
	logic [CMP_W-1:0]                 ptr_inc;
	logic [wca_pkg::SUM_W-1:0]        sum_nx;
	logic [wca_pkg::FILL_W-1:0]       fill_nx;
	logic                             sum_last;
	logic [wca_pkg::SAMPLE_W-1:0]     quo_sat;
	wca_pkg::div_req_t                div_req;
	wca_pkg::div_rsp_t                div_rsp;

	// APB register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= wca_pkg::WL_RESET;
			mode_q <= wca_pkg::MODE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				wca_pkg::REG_WINDOW: wl_q   <= pwdata[wca_pkg::WL_W-1:0];
				wca_pkg::REG_MODE:   mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			wca_pkg::REG_WINDOW: prdata = wca_pkg::PDATA_W'(wl_q);
			wca_pkg::REG_MODE:   prdata = wca_pkg::PDATA_W'(mode_q);
			default:             prdata = '0;
		endcase
	end

	// Effective window, clamped to 1..MAX_WINDOW
	always_comb begin
		wl_ext = CMP_W'(wl_q);
		if (wl_q == '0)
			win = CMP_W'(1);
		else if (wl_ext > CMP_W'(MAX_WINDOW))
			win = CMP_W'(MAX_WINDOW);
		else
			win = wl_ext;
	end

	assign samples.ready = (state_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign clr_xfer      = in_xfer && (samples.op == wca_pkg::OP_CLEAR);
	assign full_store    = in_xfer && (samples.op == wca_pkg::OP_SAMPLE) &&
		(mode_q == wca_pkg::MODE_FULL) && (samples.sample != wca_pkg::NOT_READY);

	// Store port: full mode writes at a sample transfer (not NOT_READY), warm-up after the old read
	assign mem_we  = full_store || (state_q == ST_OLD);
	assign wr_data = (state_q == ST_OLD) ? smp_q : samples.sample;
	assign rd_addr = (state_q == ST_SUM) ? idx_q[PTR_W-1:0] : ptr_q;
	assign rd_word = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ptr_q] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr_xfer)
				valid_q <= '0;
			else if (mem_we)
				valid_q[ptr_q] <= 1'b1;
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// Next pointer and warm-up sum/fill
	always_comb begin
		ptr_inc  = CMP_W'(ptr_q) + CMP_W'(1);
		sum_nx   = sum_q - wca_pkg::SUM_W'(rd_word) + wca_pkg::SUM_W'(smp_q);
		fill_nx  = (CMP_W'(fill_q) < win) ? fill_q + 1'b1 : fill_q;
		sum_last = (state_q == ST_SUM) && (idx_q == win);
	end

	// Divider request
	always_comb begin
		div_req.start = sum_last || (state_q == ST_OLD);
		if (state_q == ST_OLD) begin
			div_req.dividend = wca_pkg::ACC_W'(sum_nx);
			div_req.divisor  = fill_nx;
		end else begin
			div_req.dividend = acc_q + wca_pkg::ACC_W'(rd_word);
			div_req.divisor  = win[wca_pkg::WL_W-1:0];
		end
	end

	wca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Warm-up quotient saturates to 16 bits
	assign quo_sat = (div_rsp.quotient[wca_pkg::ACC_W-1:wca_pkg::SAMPLE_W] != '0) ?
		'1 : div_rsp.quotient[wca_pkg::SAMPLE_W-1:0];

	// Sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			held_q       <= '0;
			bus_q        <= '0;
			last_q       <= '0;
			smp_q        <= '0;
			acc_flag_q   <= 1'b0;
			wrap_q       <= 1'b0;
			div_zero_q   <= 1'b0;
			idx_q        <= '0;
			acc_q        <= '0;
			out_vld_q    <= 1'b0;
			out_latest_q <= '0;
			out_avg_q    <= '0;
			out_pub_q    <= '0;
			out_acc_q    <= 1'b0;
		end else begin
			// In the done state the result register is reloaded instead
			if (out_vld_q && results.ready && state_q != ST_DONE)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						smp_q <= samples.sample;
						if (samples.op == wca_pkg::OP_CLEAR) begin
							ptr_q      <= '0;
							fill_q     <= '0;
							sum_q      <= '0;
							held_q     <= '0;
							bus_q      <= '0;
							last_q     <= '0;
							acc_flag_q <= 1'b0;
							state_q    <= ST_DONE;
						end else if (mode_q == wca_pkg::MODE_FULL) begin
							if (samples.sample == wca_pkg::NOT_READY) begin
								acc_flag_q <= 1'b0;
								state_q    <= ST_DONE;
							end else begin
								last_q     <= samples.sample;
								ptr_q      <= (ptr_inc < win) ? ptr_inc[PTR_W-1:0] : '0;
								acc_flag_q <= 1'b1;
								acc_q      <= '0;
								idx_q      <= '0;
								state_q    <= ST_SUM;
							end
						end else begin
							acc_flag_q <= 1'b1;
							state_q    <= ST_OLD;
						end
					end
				end
				// Sweep entries 0..W-1; the read data is registered, so it lags the address
				ST_SUM: begin
					if (sum_last) begin
						state_q <= ST_DIV;
					end else begin
						if (idx_q != '0)
							acc_q <= acc_q + wca_pkg::ACC_W'(rd_word);
						idx_q <= idx_q + 1'b1;
					end
				end
				// Old entry is in the read register: update sum, fill, pointer
				ST_OLD: begin
					sum_q      <= sum_nx;
					fill_q     <= fill_nx;
					last_q     <= smp_q;
					div_zero_q <= (fill_nx == '0);
					if (ptr_inc >= win) begin
						ptr_q  <= '0;
						wrap_q <= 1'b1;
					end else begin
						ptr_q  <= ptr_inc[PTR_W-1:0];
						wrap_q <= 1'b0;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (mode_q == wca_pkg::MODE_FULL) begin
							held_q <= div_rsp.quotient[wca_pkg::SAMPLE_W-1:0];
							bus_q  <= div_rsp.quotient[wca_pkg::SAMPLE_W-1:0];
						end else begin
							held_q <= div_zero_q ? '0 : quo_sat;
							if (wrap_q)
								bus_q <= div_zero_q ? '0 : quo_sat;
						end
						state_q <= ST_DONE;
					end
				end
				// Load the result register once it is free
				ST_DONE: begin
					if (!out_vld_q || results.ready) begin
						out_vld_q    <= 1'b1;
						out_latest_q <= last_q;
						out_avg_q    <= held_q;
						out_pub_q    <= bus_q;
						out_acc_q    <= acc_flag_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid             = out_vld_q;
	assign results.latest_sample     = out_latest_q;
	assign results.average           = out_avg_q;
	assign results.published_average = out_pub_q;
	assign results.accepted          = out_acc_q;

	// A quotient only arrives while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A clear transfer empties the store and the running sum
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clr_xfer |=> (valid_q == '0 && sum_q == '0 && fill_q == '0))
		else $error("clear left state behind");

	// The store is written only at a transfer or after the old-entry read
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_OLD))
		else $error("store written during sweep or divide");

endmodule
